// File: rtl/armbnk_pkg.sv
// Package for the banked SP/LR/SPSR store: opcodes, mode codes, bank lookup.
// Used by arm_banked_register_mode_switch, armbnk_checker and tb_top; no dependencies.
package armbnk_pkg;

	localparam int DataW = 32;
	localparam int ModeW = 5;
	localparam int BankW = 3;
	localparam int NumBanks = 6;

	localparam logic [1:0] OP_MODE = 2'd0;
	localparam logic [1:0] OP_SP   = 2'd1;
	localparam logic [1:0] OP_LR   = 2'd2;
	localparam logic [1:0] OP_SPSR = 2'd3;

	localparam logic [7:0] RESET_STATUS = 8'hd3;
	localparam logic [7:0] MODE_MASK    = 8'h1f;
	localparam logic [ModeW-1:0] RESET_MODE = ModeW'(RESET_STATUS & MODE_MASK);

	localparam logic [ModeW-1:0] MODE_NONE = 5'h00;
	localparam logic [ModeW-1:0] MODE_USR  = 5'h10;
	localparam logic [ModeW-1:0] MODE_FIQ  = 5'h11;
	localparam logic [ModeW-1:0] MODE_IRQ  = 5'h12;
	localparam logic [ModeW-1:0] MODE_SVC  = 5'h13;
	localparam logic [ModeW-1:0] MODE_ABT  = 5'h17;
	localparam logic [ModeW-1:0] MODE_UND  = 5'h1b;

	localparam logic [BankW-1:0] BANK_USR = 3'd0;
	localparam logic [BankW-1:0] BANK_FIQ = 3'd1;
	localparam logic [BankW-1:0] BANK_IRQ = 3'd2;
	localparam logic [BankW-1:0] BANK_SVC = 3'd3;
	localparam logic [BankW-1:0] BANK_ABT = 3'd4;
	localparam logic [BankW-1:0] BANK_UND = 3'd5;
	localparam logic [BankW-1:0] RESET_BANK = BANK_SVC;
	localparam logic [BankW-1:0] LAST_BANK = BankW'(NumBanks - 1);

	typedef struct packed {
		logic             hit;
		logic [BankW-1:0] idx;
	} bank_sel_t;

	function automatic bank_sel_t bank_of(input logic [ModeW-1:0] mode);
		bank_sel_t sel;
		sel.hit = 1'b1;
		unique case (mode)
			MODE_USR: sel.idx = BANK_USR;
			MODE_FIQ: sel.idx = BANK_FIQ;
			MODE_IRQ: sel.idx = BANK_IRQ;
			MODE_SVC: sel.idx = BANK_SVC;
			MODE_ABT: sel.idx = BANK_ABT;
			MODE_UND: sel.idx = BANK_UND;
			default: begin
				sel.hit = 1'b0;
				sel.idx = BANK_USR;
			end
		endcase
		return sel;
	endfunction

endpackage

// File: rtl/arm_banked_register_mode_switch.sv
// Banked SP/LR/SPSR store with mode switching: input register, update logic,
// result register. Depends on armbnk_pkg.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | opcode, requested_mode, write_value
//  out     | out_valid / out_stall| current_sp, current_lr, current_spsr,
//          |                      | active_mode, active_bank, mode_changed, bad_request
//
// One item per cycle sustained unless out_stall holds a valid result; results are registered.
// The banked state updates as an item moves from the input register to the result register.
// A stalled result holds the input register; in_stall rises only when both are full.
// arst_n resets mode to supervisor, bank to 3 and all live and banked registers to zero.
module arm_banked_register_mode_switch (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic [armbnk_pkg::ModeW-1:0]        requested_mode,
	input  logic [armbnk_pkg::DataW-1:0]        write_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [armbnk_pkg::DataW-1:0]        current_sp,
	output logic [armbnk_pkg::DataW-1:0]        current_lr,
	output logic [armbnk_pkg::DataW-1:0]        current_spsr,
	output logic [armbnk_pkg::ModeW-1:0]        active_mode,
	output logic [armbnk_pkg::BankW-1:0]        active_bank,
	output logic                                mode_changed,
	output logic                                bad_request
);

	logic                          valid_s1;
	logic [1:0]                    opcode_s1;
	logic [armbnk_pkg::ModeW-1:0]  mode_s1;
	logic [armbnk_pkg::DataW-1:0]  value_s1;

	logic [armbnk_pkg::ModeW-1:0]  mode_q;
	logic [armbnk_pkg::BankW-1:0]  bank_q;
	logic [armbnk_pkg::DataW-1:0]  sp_q, lr_q, spsr_q;
	logic [armbnk_pkg::DataW-1:0]  saved_sp_q   [armbnk_pkg::NumBanks];
	logic [armbnk_pkg::DataW-1:0]  saved_lr_q   [armbnk_pkg::NumBanks];
	logic [armbnk_pkg::DataW-1:0]  saved_spsr_q [armbnk_pkg::NumBanks];

	logic                          out_valid_q;
	logic                          advance, accept;
	logic                          switch_go;
	armbnk_pkg::bank_sel_t         old_sel, new_sel;
	logic [armbnk_pkg::ModeW-1:0]  mode_nx;
	logic [armbnk_pkg::BankW-1:0]  bank_nx;
	logic [armbnk_pkg::DataW-1:0]  sp_nx, lr_nx, spsr_nx;
	logic                          changed_nx, bad_nx;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign old_sel = armbnk_pkg::bank_of(mode_q);
	assign new_sel = armbnk_pkg::bank_of(mode_s1);

	always_comb begin
		mode_nx    = mode_q;
		bank_nx    = bank_q;
		sp_nx      = sp_q;
		lr_nx      = lr_q;
		spsr_nx    = spsr_q;
		changed_nx = 1'b0;
		bad_nx     = 1'b0;
		switch_go  = 1'b0;
		unique case (opcode_s1)
			armbnk_pkg::OP_SP:   sp_nx   = value_s1;
			armbnk_pkg::OP_LR:   lr_nx   = value_s1;
			armbnk_pkg::OP_SPSR: spsr_nx = value_s1;
			armbnk_pkg::OP_MODE: begin
				if (mode_s1 != mode_q) begin
					if (mode_s1 == armbnk_pkg::MODE_NONE) begin
						bad_nx = 1'b1;
					end else begin
						switch_go  = 1'b1;
						changed_nx = 1'b1;
						mode_nx    = mode_s1;
						if (new_sel.hit) begin
							sp_nx   = saved_sp_q[new_sel.idx];
							lr_nx   = saved_lr_q[new_sel.idx];
							bank_nx = new_sel.idx;
							if (new_sel.idx != armbnk_pkg::BANK_USR) begin
								spsr_nx = saved_spsr_q[new_sel.idx];
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			mode_s1   <= requested_mode;
			value_s1  <= write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= armbnk_pkg::RESET_MODE;
			bank_q <= armbnk_pkg::RESET_BANK;
			sp_q   <= '0;
			lr_q   <= '0;
			spsr_q <= '0;
			for (int i = 0; i < armbnk_pkg::NumBanks; i++) begin
				saved_sp_q[i]   <= '0;
				saved_lr_q[i]   <= '0;
				saved_spsr_q[i] <= '0;
			end
		end else if (advance) begin
			mode_q <= mode_nx;
			bank_q <= bank_nx;
			sp_q   <= sp_nx;
			lr_q   <= lr_nx;
			spsr_q <= spsr_nx;
			if (switch_go && old_sel.hit) begin
				saved_sp_q[old_sel.idx] <= sp_q;
				saved_lr_q[old_sel.idx] <= lr_q;
				if (old_sel.idx != armbnk_pkg::BANK_USR) begin
					saved_spsr_q[old_sel.idx] <= spsr_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			current_sp   <= sp_nx;
			current_lr   <= lr_nx;
			current_spsr <= spsr_nx;
			active_mode  <= mode_nx;
			active_bank  <= bank_nx;
			mode_changed <= changed_nx;
			bad_request  <= bad_nx;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/armbnk_checker.sv
// Port-level checks for arm_banked_register_mode_switch, bound to the top level.
// Depends on armbnk_pkg.
module armbnk_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [armbnk_pkg::DataW-1:0]        current_sp,
	input logic [armbnk_pkg::ModeW-1:0]        active_mode,
	input logic [armbnk_pkg::BankW-1:0]        active_bank,
	input logic                                mode_changed,
	input logic                                bad_request
);

	logic [armbnk_pkg::ModeW-1:0] last_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mode_q <= armbnk_pkg::RESET_MODE;
		end else if (out_valid && !out_stall) begin
			last_mode_q <= active_mode;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(current_sp) && $stable(active_mode))
		else $error("stalled result changed");

	a_bank_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_bank <= armbnk_pkg::LAST_BANK)
		else $error("bank out of range");

	a_bad_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_request |-> !mode_changed && active_mode == last_mode_q)
		else $error("bad request altered mode");

	a_switch_moves: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_changed |-> active_mode != last_mode_q)
		else $error("switch kept mode");

endmodule

bind arm_banked_register_mode_switch armbnk_checker u_armbnk_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for arm_banked_register_mode_switch: directed and random
// mode requests and SP/LR/SPSR writes, checked against a behavioral bank model.
// Depends on armbnk_pkg and the block's RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [armbnk_pkg::ModeW-1:0] MODE_SYS = 5'h1f;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 900;

	typedef struct packed {
		logic [armbnk_pkg::DataW-1:0] sp;
		logic [armbnk_pkg::DataW-1:0] lr;
		logic [armbnk_pkg::DataW-1:0] spsr;
		logic [armbnk_pkg::ModeW-1:0] mode;
		logic [armbnk_pkg::BankW-1:0] bank;
		logic                         changed;
		logic                         bad;
	} bank_view_t;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [1:0]                   opcode = armbnk_pkg::OP_SP;
	logic [armbnk_pkg::ModeW-1:0] requested_mode = '0;
	logic [armbnk_pkg::DataW-1:0] write_value = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [armbnk_pkg::DataW-1:0] current_sp;
	logic [armbnk_pkg::DataW-1:0] current_lr;
	logic [armbnk_pkg::DataW-1:0] current_spsr;
	logic [armbnk_pkg::ModeW-1:0] active_mode;
	logic [armbnk_pkg::BankW-1:0] active_bank;
	logic                         mode_changed;
	logic                         bad_request;

	// model state
	logic [armbnk_pkg::ModeW-1:0] cur_mode = armbnk_pkg::RESET_MODE;
	logic [armbnk_pkg::BankW-1:0] cur_bank = armbnk_pkg::RESET_BANK;
	logic [armbnk_pkg::DataW-1:0] live_sp = '0;
	logic [armbnk_pkg::DataW-1:0] live_lr = '0;
	logic [armbnk_pkg::DataW-1:0] live_spsr = '0;
	logic [armbnk_pkg::DataW-1:0] bank_sp [armbnk_pkg::NumBanks] = '{default: '0};
	logic [armbnk_pkg::DataW-1:0] bank_lr [armbnk_pkg::NumBanks] = '{default: '0};
	logic [armbnk_pkg::DataW-1:0] bank_spsr [armbnk_pkg::NumBanks] = '{default: '0};
	logic [armbnk_pkg::ModeW-1:0] banked_modes [armbnk_pkg::NumBanks] =
		'{armbnk_pkg::MODE_USR, armbnk_pkg::MODE_FIQ, armbnk_pkg::MODE_IRQ,
		  armbnk_pkg::MODE_SVC, armbnk_pkg::MODE_ABT, armbnk_pkg::MODE_UND};

	bank_view_t pending_views [$];
	int mismatches = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	arm_banked_register_mode_switch DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.requested_mode(requested_mode),
		.write_value(write_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.current_sp(current_sp),
		.current_lr(current_lr),
		.current_spsr(current_spsr),
		.active_mode(active_mode),
		.active_bank(active_bank),
		.mode_changed(mode_changed),
		.bad_request(bad_request)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int bank_slot(input logic [armbnk_pkg::ModeW-1:0] mode);
		for (int i = 0; i < armbnk_pkg::NumBanks; i++)
			if (banked_modes[i] == mode) return i;
		return -1;
	endfunction

	function automatic bank_view_t apply_item(input logic [1:0] op,
			input logic [armbnk_pkg::ModeW-1:0] req, input logic [armbnk_pkg::DataW-1:0] val);
		bank_view_t v;
		int old_slot;
		int new_slot;
		v = '0;
		case (op)
			armbnk_pkg::OP_SP: live_sp = val;
			armbnk_pkg::OP_LR: live_lr = val;
			armbnk_pkg::OP_SPSR: live_spsr = val;
			default: begin
				if (req == armbnk_pkg::MODE_NONE && cur_mode != armbnk_pkg::MODE_NONE) begin
					v.bad = 1'b1;
				end else if (req != cur_mode) begin
					old_slot = bank_slot(cur_mode);
					new_slot = bank_slot(req);
					if (old_slot >= 0) begin
						bank_sp[old_slot] = live_sp;
						bank_lr[old_slot] = live_lr;
						if (old_slot != armbnk_pkg::BANK_USR) bank_spsr[old_slot] = live_spsr;
					end
					if (new_slot >= 0) begin
						live_sp = bank_sp[new_slot];
						live_lr = bank_lr[new_slot];
						if (new_slot != armbnk_pkg::BANK_USR) live_spsr = bank_spsr[new_slot];
						cur_bank = armbnk_pkg::BankW'(new_slot);
					end
					cur_mode = req;
					v.changed = 1'b1;
				end
			end
		endcase
		v.sp = live_sp;
		v.lr = live_lr;
		v.spsr = live_spsr;
		v.mode = cur_mode;
		v.bank = cur_bank;
		return v;
	endfunction

	function automatic int pick_idle();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void compare_field(input string name,
			input logic [armbnk_pkg::DataW-1:0] want, input logic [armbnk_pkg::DataW-1:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	// Called just after a rising edge; returns at the edge that accepts the item.
	task automatic send_item(input logic [1:0] op, input logic [armbnk_pkg::ModeW-1:0] req,
			input logic [armbnk_pkg::DataW-1:0] val);
		int gap;
		bank_view_t view;
		gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		requested_mode <= req;
		write_value <= val;
		do @(posedge clk); while (in_stall);
		view = apply_item(op, req, val);
		pending_views = {pending_views, view};
	endtask

	task automatic request_mode(input logic [armbnk_pkg::ModeW-1:0] mode);
		send_item(armbnk_pkg::OP_MODE, mode, $urandom);
	endtask

	task automatic write_reg(input logic [1:0] op, input logic [armbnk_pkg::DataW-1:0] val);
		send_item(op, armbnk_pkg::ModeW'($urandom), val);
	endtask

	always @(posedge clk) begin
		bank_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_views.size() == 0) begin
				$error("result with no item outstanding");
				mismatches++;
			end else begin
				want = pending_views.pop_front();
				compare_field("current_sp", want.sp, current_sp);
				compare_field("current_lr", want.lr, current_lr);
				compare_field("current_spsr", want.spsr, current_spsr);
				compare_field("active_mode", armbnk_pkg::DataW'(want.mode),
					armbnk_pkg::DataW'(active_mode));
				compare_field("active_bank", armbnk_pkg::DataW'(want.bank),
					armbnk_pkg::DataW'(active_bank));
				compare_field("mode_changed", armbnk_pkg::DataW'(want.changed),
					armbnk_pkg::DataW'(mode_changed));
				compare_field("bad_request", armbnk_pkg::DataW'(want.bad),
					armbnk_pkg::DataW'(bad_request));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			stall_left = pick_idle() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic test_reset_state();
		request_mode(armbnk_pkg::MODE_SVC);
	endtask

	task automatic test_register_writes();
		write_reg(armbnk_pkg::OP_SP, 32'hffff_ffff);
		write_reg(armbnk_pkg::OP_LR, 32'hffff_ffff);
		write_reg(armbnk_pkg::OP_SPSR, 32'hffff_ffff);
		write_reg(armbnk_pkg::OP_SP, 32'h0000_0000);
		write_reg(armbnk_pkg::OP_LR, 32'ha5a5_5a5a);
	endtask

	task automatic test_mode_switches();
		request_mode(armbnk_pkg::MODE_FIQ);
		write_reg(armbnk_pkg::OP_SP, 32'h1234_5678);
		request_mode(armbnk_pkg::MODE_IRQ);
		request_mode(armbnk_pkg::MODE_ABT);
		request_mode(armbnk_pkg::MODE_UND);
		request_mode(armbnk_pkg::MODE_USR);
		write_reg(armbnk_pkg::OP_SPSR, 32'h5a5a_a5a5);
		request_mode(armbnk_pkg::MODE_SVC);
		request_mode(armbnk_pkg::MODE_FIQ);
	endtask

	task automatic test_unbanked_modes();
		request_mode(MODE_SYS);
		write_reg(armbnk_pkg::OP_SP, 32'hdead_beef);
		request_mode(armbnk_pkg::MODE_NONE);
		request_mode(5'h0e);
		request_mode(armbnk_pkg::MODE_USR);
		request_mode(armbnk_pkg::MODE_SVC);
	endtask

	task automatic test_random_traffic();
		logic [armbnk_pkg::ModeW-1:0] mode_pool [8] =
			'{armbnk_pkg::MODE_USR, armbnk_pkg::MODE_FIQ, armbnk_pkg::MODE_IRQ,
			  armbnk_pkg::MODE_SVC, armbnk_pkg::MODE_ABT, armbnk_pkg::MODE_UND,
			  MODE_SYS, armbnk_pkg::MODE_NONE};
		int sent;
		int run;
		logic [armbnk_pkg::DataW-1:0] val;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			run = $urandom_range(20, 60);
			for (int i = 0; i < run && sent < RANDOM_ITEMS; i++) begin
				if ($urandom_range(0, 99) < 45) begin
					if ($urandom_range(0, 3) != 0)
						request_mode(mode_pool[$urandom_range(0, 6 + ($urandom_range(0, 9) == 0))]);
					else
						request_mode(armbnk_pkg::ModeW'($urandom));
				end else begin
					case ($urandom_range(0, 6))
						0: val = 32'h0;
						1: val = 32'hffff_ffff;
						2: val = 32'h1 << $urandom_range(0, 31);
						default: val = $urandom;
					endcase
					write_reg(armbnk_pkg::OP_SP + 2'($urandom_range(0, 2)), val);
				end
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_register_writes();
		test_mode_switches();
		test_unbanked_modes();
		test_random_traffic();
		in_valid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/armbnk_pkg.sv
rtl/arm_banked_register_mode_switch.sv
rtl/armbnk_checker.sv
tb/sv/tb_top.sv
